>>> rtl/core/process_grid_partition_select_assert.svh
// assertion macros for the partition selector
`ifndef PROCESS_GRID_PARTITION_SELECT_ASSERT_SVH
`define PROCESS_GRID_PARTITION_SELECT_ASSERT_SVH
`ifndef SYNTH
// condition and consequence in the same cycle
`define PGPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("partition selector check failed");
// consequence in the cycle after the condition
`define PGPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("partition selector check failed");
`else
`define PGPS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PGPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/pgps_pkg.sv
package pgps_pkg;

    // field widths
    localparam int PART_BITS = 13;
    localparam int NODE_BITS = 16;
    localparam int MAX_PARTS = 4096;
    localparam int PROD_BITS = 2 * NODE_BITS;
    localparam int COST_BITS = 48;
    // search counter: runs to one past the square root of the largest part count
    localparam int CNT_BITS  = 7;
    // quotient register of the divider, two passes of seven bits
    localparam int DIV_STEP  = 7;
    localparam int QUO_BITS  = 2 * DIV_STEP;
    localparam int IN_BITS   = PART_BITS + 3 * NODE_BITS + 3;
    localparam int OUT_BITS  = 3 * PART_BITS + 1;

    // sequencer states
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_PROD = 9'b000000010,
        S_ODIV = 9'b000000100,
        S_OCHK = 9'b000001000,
        S_IDIV = 9'b000010000,
        S_ICHK = 9'b000100000,
        S_EVAL = 9'b001000000,
        S_CMP  = 9'b010000000,
        S_DONE = 9'b100000000
    } t_state;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic       load;
        logic       prod;
        logic       div_en;
        logic       div_first;
        logic       div_inner;
        logic       outer_hit;
        logic       next_a;
        logic       swap_side;
        logic       next_b;
        logic       inner_hit;
        logic       eval;
        logic       cmp;
        logic       flip_iside;
        logic       publish;
        logic [1:0] step;
    } t_cmd;

    // status from the datapath to the sequencer
    typedef struct packed {
        logic req_bad;
        logic a_gt_q;
        logic b_gt_q;
        logic rem_zero;
        logic oside;
        logic iside;
    } t_status;

endpackage

>>> rtl/core/pgps_dp.sv
module pgps_dp (
    input  logic                       i_clk,
    input  pgps_pkg::t_cmd             i_cmd,
    input  logic [pgps_pkg::IN_BITS-1:0]  i_in_data,
    output pgps_pkg::t_status          o_status,
    output logic [pgps_pkg::OUT_BITS-1:0] o_out_data
);

    localparam int PB = pgps_pkg::PART_BITS;
    localparam int NB = pgps_pkg::NODE_BITS;
    localparam int CB = pgps_pkg::CNT_BITS;
    localparam int DS = pgps_pkg::DIV_STEP;
    localparam int QB = pgps_pkg::QUO_BITS;
    localparam int MB = pgps_pkg::PROD_BITS + NB;

    // incoming fields
    logic [PB-1:0] in_parts;
    logic [NB-1:0] in_nx, in_ny, in_nz;
    logic          in_ax, in_ay, in_az;

    // request registers
    logic [PB-1:0] r_parts;
    logic [NB-1:0] r_nx, r_ny, r_nz;
    logic          r_ax, r_ay, r_az;
    logic [pgps_pkg::PROD_BITS-1:0] r_nxy, r_nxz, r_nyz;

    // search registers
    logic [CB-1:0] r_a, r_b;
    logic [PB-1:0] r_pa, r_px, r_rest, r_qb;
    logic          r_oside, r_iside;

    // divider registers
    logic [CB-1:0] r_rem, r_dvs;
    logic [DS-1:0] r_dvd_lo;
    logic [QB-1:0] r_quo;

    // cost registers
    logic [MB-1:0] r_prod;
    logic [pgps_pkg::COST_BITS-1:0] r_acc, r_best_cost;
    logic [PB-1:0] r_bx, r_by, r_bz;
    logic          r_found;
    logic [pgps_pkg::OUT_BITS-1:0] r_out;

    logic [pgps_pkg::PROD_BITS-1:0] mul_a;
    logic [NB-1:0]  mul_b;
    logic [MB-1:0]  mul_p;
    logic [PB-1:0]  py, pz;
    logic [QB-1:0]  dvd_full;
    logic [CB-1:0]  dvs_sel, rem_in;
    logic [DS-1:0]  bits_in;
    logic [CB+DS-1:0] div_res;
    logic           elig, key_gt, win;
    logic [pgps_pkg::COST_BITS-1:0] acc_sum;

    // seven restoring division steps
    function automatic logic [CB+DS-1:0] div_steps(input logic [CB-1:0] rem,
                                                   input logic [DS-1:0] bits,
                                                   input logic [CB-1:0] dvs);
        logic [CB:0]   t;
        logic [CB-1:0] r;
        logic [DS-1:0] q;
        r = rem;
        q = '0;
        for (int i = DS - 1; i >= 0; i--) begin
            t = {r, bits[i]};
            if (t >= {1'b0, dvs}) begin
                t    = t - {1'b0, dvs};
                q[i] = 1'b1;
            end
            r = t[CB-1:0];
        end
        return {r, q};
    endfunction

    // unpack the request
    assign in_parts = i_in_data[PB-1:0];
    assign in_nx    = i_in_data[PB+NB-1:PB];
    assign in_ny    = i_in_data[PB+2*NB-1:PB+NB];
    assign in_nz    = i_in_data[PB+3*NB-1:PB+2*NB];
    assign in_ax    = i_in_data[PB+3*NB];
    assign in_ay    = i_in_data[PB+3*NB+1];
    assign in_az    = i_in_data[PB+3*NB+2];

    // current triple
    // note: first side is (px, b, rest/b), second is (px, rest/b, b)
    always_comb begin
        py = r_iside ? r_qb : {{(PB-CB){1'b0}}, r_b};
        pz = r_iside ? {{(PB-CB){1'b0}}, r_b} : r_qb;
    end

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (i_cmd.prod) begin
            case (i_cmd.step)
                2'd0: begin
                    mul_a = {{NB{1'b0}}, r_nx};
                    mul_b = r_ny;
                end
                2'd1: begin
                    mul_a = {{NB{1'b0}}, r_nx};
                    mul_b = r_nz;
                end
                default: begin
                    mul_a = {{NB{1'b0}}, r_ny};
                    mul_b = r_nz;
                end
            endcase
        end else begin
            case (i_cmd.step)
                2'd0: begin
                    mul_a = r_nxy;
                    mul_b = {{(NB-PB){1'b0}}, pz};
                end
                2'd1: begin
                    mul_a = r_nxz;
                    mul_b = {{(NB-PB){1'b0}}, py};
                end
                default: begin
                    mul_a = r_nyz;
                    mul_b = {{(NB-PB){1'b0}}, r_px};
                end
            endcase
        end
    end

    assign mul_p   = mul_a * mul_b;
    assign acc_sum = r_acc + r_prod;

    // divider operand selection
    assign dvd_full = i_cmd.div_inner ? {{(QB-PB){1'b0}}, r_rest}
                                      : {{(QB-PB){1'b0}}, r_parts};
    assign dvs_sel  = i_cmd.div_first ? (i_cmd.div_inner ? r_b : r_a) : r_dvs;
    assign rem_in   = i_cmd.div_first ? '0 : r_rem;
    assign bits_in  = i_cmd.div_first ? dvd_full[QB-1:DS] : r_dvd_lo;
    assign div_res  = div_steps(rem_in, bits_in, dvs_sel);

    // selection rule: eligible triple of least cost, larger (x, y) split on a tie
    assign elig   = (r_ax || r_px == PB'(1)) && (r_ay || py == PB'(1))
                 && (r_az || pz == PB'(1));
    assign key_gt = {r_px, py} > {r_bx, r_by};
    assign win    = elig && ((r_acc < r_best_cost) || (r_acc == r_best_cost && key_gt));

    always_ff @(posedge i_clk) begin
        // take a new request
        if (i_cmd.load) begin
            r_parts     <= in_parts;
            r_nx        <= in_nx;
            r_ny        <= in_ny;
            r_nz        <= in_nz;
            r_ax        <= in_ax;
            r_ay        <= in_ay;
            r_az        <= in_az;
            r_best_cost <= '1;
            r_bx        <= '0;
            r_by        <= '0;
            r_bz        <= '0;
            r_found     <= 1'b0;
            r_a         <= CB'(1);
        end
        // pairwise node products
        if (i_cmd.prod) begin
            case (i_cmd.step)
                2'd0:    r_nxy <= mul_p[pgps_pkg::PROD_BITS-1:0];
                2'd1:    r_nxz <= mul_p[pgps_pkg::PROD_BITS-1:0];
                default: r_nyz <= mul_p[pgps_pkg::PROD_BITS-1:0];
            endcase
        end
        // divider passes
        if (i_cmd.div_en) begin
            r_rem <= div_res[CB+DS-1:DS];
            if (i_cmd.div_first) begin
                r_quo[QB-1:DS] <= div_res[DS-1:0];
                r_dvd_lo       <= dvd_full[DS-1:0];
                r_dvs          <= dvs_sel;
            end else begin
                r_quo[DS-1:0]  <= div_res[DS-1:0];
            end
        end
        // outer and inner search walk
        if (i_cmd.outer_hit) begin
            r_pa    <= r_quo[PB-1:0];
            r_px    <= {{(PB-CB){1'b0}}, r_a};
            r_rest  <= r_quo[PB-1:0];
            r_oside <= 1'b0;
            r_b     <= CB'(1);
        end
        if (i_cmd.swap_side) begin
            r_px    <= r_pa;
            r_rest  <= {{(PB-CB){1'b0}}, r_a};
            r_oside <= 1'b1;
            r_b     <= CB'(1);
        end
        if (i_cmd.next_a) begin
            r_a <= r_a + CB'(1);
        end
        if (i_cmd.next_b) begin
            r_b <= r_b + CB'(1);
        end
        if (i_cmd.inner_hit) begin
            r_qb    <= r_quo[PB-1:0];
            r_iside <= 1'b0;
        end
        if (i_cmd.flip_iside) begin
            r_iside <= 1'b1;
        end
        // cost accumulation, product registered before the add
        if (i_cmd.eval) begin
            r_prod <= mul_p;
            case (i_cmd.step)
                2'd0:    r_acc <= r_acc;
                2'd1:    r_acc <= r_prod[pgps_pkg::COST_BITS-1:0];
                default: r_acc <= acc_sum;
            endcase
        end
        // keep the best triple
        if (i_cmd.cmp && win) begin
            r_best_cost <= r_acc;
            r_bx        <= r_px;
            r_by        <= py;
            r_bz        <= pz;
            r_found     <= 1'b1;
        end
        // result register
        if (i_cmd.publish) begin
            r_out <= {r_found, r_bz, r_by, r_bx};
        end
    end

    assign o_status.req_bad  = (in_parts == '0) || (in_parts > PB'(pgps_pkg::MAX_PARTS))
                            || !(in_ax || in_ay || in_az);
    assign o_status.a_gt_q   = {{(QB-CB){1'b0}}, r_a} > r_quo;
    assign o_status.b_gt_q   = {{(QB-CB){1'b0}}, r_b} > r_quo;
    assign o_status.rem_zero = (r_rem == '0);
    assign o_status.oside    = r_oside;
    assign o_status.iside    = r_iside;
    assign o_out_data        = r_out;

endmodule

>>> rtl/core/pgps_ctrl.sv
module pgps_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  pgps_pkg::t_status i_status,
    output pgps_pkg::t_cmd    o_cmd
);

    pgps_pkg::t_state r_state, n_state;
    logic [1:0]       r_step, n_step;
    logic             r_ovalid, n_ovalid;
    pgps_pkg::t_cmd   cmd;

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_step     = '0;
        cmd        = '0;
        cmd.step   = r_step;
        o_in_ready = 1'b0;
        case (r_state)
            pgps_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = i_status.req_bad ? pgps_pkg::S_DONE : pgps_pkg::S_PROD;
                end
            end
            pgps_pkg::S_PROD: begin
                cmd.prod = 1'b1;
                if (r_step == 2'd2) begin
                    n_state = pgps_pkg::S_ODIV;
                end else begin
                    n_step = r_step + 2'd1;
                end
            end
            pgps_pkg::S_ODIV: begin
                cmd.div_en    = 1'b1;
                cmd.div_first = (r_step == 2'd0);
                if (r_step == 2'd1) begin
                    n_state = pgps_pkg::S_OCHK;
                end else begin
                    n_step = r_step + 2'd1;
                end
            end
            pgps_pkg::S_OCHK: begin
                if (i_status.a_gt_q) begin
                    n_state = pgps_pkg::S_DONE;
                end else if (i_status.rem_zero) begin
                    cmd.outer_hit = 1'b1;
                    n_state       = pgps_pkg::S_IDIV;
                end else begin
                    cmd.next_a = 1'b1;
                    n_state    = pgps_pkg::S_ODIV;
                end
            end
            pgps_pkg::S_IDIV: begin
                cmd.div_en    = 1'b1;
                cmd.div_inner = 1'b1;
                cmd.div_first = (r_step == 2'd0);
                if (r_step == 2'd1) begin
                    n_state = pgps_pkg::S_ICHK;
                end else begin
                    n_step = r_step + 2'd1;
                end
            end
            pgps_pkg::S_ICHK: begin
                if (i_status.b_gt_q) begin
                    if (!i_status.oside) begin
                        cmd.swap_side = 1'b1;
                        n_state       = pgps_pkg::S_IDIV;
                    end else begin
                        cmd.next_a = 1'b1;
                        n_state    = pgps_pkg::S_ODIV;
                    end
                end else if (i_status.rem_zero) begin
                    cmd.inner_hit = 1'b1;
                    n_state       = pgps_pkg::S_EVAL;
                end else begin
                    cmd.next_b = 1'b1;
                    n_state    = pgps_pkg::S_IDIV;
                end
            end
            pgps_pkg::S_EVAL: begin
                cmd.eval = 1'b1;
                if (r_step == 2'd3) begin
                    n_state = pgps_pkg::S_CMP;
                end else begin
                    n_step = r_step + 2'd1;
                end
            end
            pgps_pkg::S_CMP: begin
                cmd.cmp = 1'b1;
                if (!i_status.iside) begin
                    cmd.flip_iside = 1'b1;
                    n_state        = pgps_pkg::S_EVAL;
                end else begin
                    cmd.next_b = 1'b1;
                    n_state    = pgps_pkg::S_IDIV;
                end
            end
            pgps_pkg::S_DONE: begin
                // wait for the result register to free up
                if (!r_ovalid || i_out_ready) begin
                    cmd.publish = 1'b1;
                    n_state     = pgps_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pgps_pkg::S_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb begin
        n_ovalid = r_ovalid;
        if (cmd.publish) begin
            n_ovalid = 1'b1;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pgps_pkg::S_IDLE;
            r_step   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_cmd       = cmd;
    assign o_out_valid = r_ovalid;

endmodule

>>> rtl/core/process_grid_partition_select.sv
// channel  | direction | tdata fields, lowest bit first
// ---------+-----------+-----------------------------------------------------------
// s_axis   | in        | part_count[12:0] nodes_x[28:13] nodes_y[44:29]
//          |           | nodes_z[60:45] allow_x[61] allow_y[62] allow_z[63]
// m_axis   | out       | split_x[12:0] split_y[25:13] split_z[38:26] found[39]
//
// one item at a time: a rejected request (zero or oversize part count, no axis) goes straight
// to publish; else accept, node products, outer candidates a up to the first a with a*a > P,
// inner candidates b up to the first b with b*b > rest on each side of a divisor pair,
// evaluation of both orders per inner divisor found, publish (two-pass divider, one multiplier)
// reset is synchronous, active low, and clears the sequencer and result valid
// a new item is taken while a result waits; a search ending first stalls until it is taken
`include "process_grid_partition_select_assert.svh"

module process_grid_partition_select (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // part_count, nodes_x, nodes_y, nodes_z, allow_x, allow_y, allow_z
    input  logic [pgps_pkg::IN_BITS-1:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // split_x, split_y, split_z, found
    output logic [pgps_pkg::OUT_BITS-1:0] m_axis_tdata
);

    pgps_pkg::t_cmd    cmd;
    pgps_pkg::t_status status;

    // result and handshake terms for the checks
    logic res_found, res_zero, res_all_set, in_take;

    // sequencer
    pgps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // search datapath
    pgps_dp u_dp (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_in_data  (s_axis_tdata),
        .o_status   (status),
        .o_out_data (m_axis_tdata)
    );

    assign res_found   = m_axis_tdata[39];
    assign res_zero    = (m_axis_tdata[38:0] == '0);
    assign res_all_set = (m_axis_tdata[12:0] != '0) && (m_axis_tdata[25:13] != '0)
                      && (m_axis_tdata[38:26] != '0);
    assign in_take     = s_axis_tvalid && s_axis_tready;

    // no result means all factors zero
    `PGPS_ASSERT_SAME(a_none_zero, i_clk, i_rst_n, m_axis_tvalid && !res_found, res_zero)
    // a chosen triple has no zero factor
    `PGPS_ASSERT_SAME(a_found_nonzero, i_clk, i_rst_n, m_axis_tvalid && res_found, res_all_set)
    // busy right after taking an item
    `PGPS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_take, !s_axis_tready)

endmodule
